### rtl/gcas_pkg.sv
package gcas_pkg;

	// Function codes of an input item
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_RUN   = 2'd2;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_PASS_COUNT   = 3'd2;
	localparam logic [2:0] REG_CROWD_LIMIT  = 3'd3;
	localparam logic [2:0] REG_SPARSE_LIMIT = 3'd4;

	localparam int APB_AW = 5;

	// Register reset values
	localparam logic [6:0]        GRID_DIM_RESET     = 7'd64;
	localparam logic [3:0]        PASS_COUNT_RESET   = 4'd1;
	localparam logic [3:0]        CROWD_LIMIT_RESET  = 4'd5;
	localparam logic signed [4:0] SPARSE_LIMIT_RESET = 5'sd0;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       wall_in;
	} req_t;

	typedef struct packed {
		logic wall_out;
		logic status;
	} rsp_t;

	typedef struct packed {
		logic [6:0]        grid_width;
		logic [6:0]        grid_height;
		logic [3:0]        pass_count;
		logic [3:0]        crowd_limit;
		logic signed [4:0] sparse_limit;
	} cfg_t;

endpackage

### rtl/gcas_ram.sv
module gcas_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/gcas_cfg.sv
module gcas_cfg import gcas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_AW-1:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.grid_width   <= GRID_DIM_RESET;
			cfg.grid_height  <= GRID_DIM_RESET;
			cfg.pass_count   <= PASS_COUNT_RESET;
			cfg.crowd_limit  <= CROWD_LIMIT_RESET;
			cfg.sparse_limit <= SPARSE_LIMIT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GRID_WIDTH:   cfg.grid_width   <= pwdata[6:0];
				REG_GRID_HEIGHT:  cfg.grid_height  <= pwdata[6:0];
				REG_PASS_COUNT:   cfg.pass_count   <= pwdata[3:0];
				REG_CROWD_LIMIT:  cfg.crowd_limit  <= pwdata[3:0];
				REG_SPARSE_LIMIT: cfg.sparse_limit <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_GRID_WIDTH:   prdata = {25'd0, cfg.grid_width};
			REG_GRID_HEIGHT:  prdata = {25'd0, cfg.grid_height};
			REG_PASS_COUNT:   prdata = {28'd0, cfg.pass_count};
			REG_CROWD_LIMIT:  prdata = {28'd0, cfg.crowd_limit};
			REG_SPARSE_LIMIT: prdata = {27'd0, cfg.sparse_limit};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

### rtl/gcas_engine.sv
module gcas_engine import gcas_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  req_t                         req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output rsp_t                         rsp,
	output logic                         mem_we,
	output logic [$clog2(MAX_WIDTH)-1:0] mem_waddr,
	output logic [MAX_HEIGHT-1:0]        mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(MAX_WIDTH)-1:0] mem_raddr,
	input  logic [MAX_HEIGHT-1:0]        mem_rdata
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT);
	localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DW0  = $clog2(MAXD + 1);
	localparam int DW   = (DW0 > 7) ? DW0 : 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL_DATA,
		ST_LOAD0,
		ST_LOAD1,
		ST_LOAD2,
		ST_LOAD3,
		ST_CELL,
		ST_COL,
		ST_FILL,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [DW-1:0]         eff_w, eff_h;
	logic                  tiny;
	logic                  out_rng;
	logic                  y_last, col_last, pass_last;
	logic [XW-1:0]         x_q;
	logic [YW-1:0]         y_q;
	logic [YW-1:0]         ym, yp;
	logic [3:0]            pass_q;
	logic [MAX_WIDTH-1:0]  col_vld_q;
	logic                  rd_vld_q;
	logic [MAX_HEIGHT-1:0] rd_col;
	logic [MAX_HEIGHT-1:0] cell_col;
	logic [MAX_HEIGHT-1:0] prev_q, cur_q, next_q;
	logic [YW-1:0]         cy;
	logic [3:0]            cnt;
	logic                  cell_wall;
	req_t                  req_q;
	logic                  res_wall_q, res_status_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  rsp_load;

	// Effective grid size and range checks
	assign eff_w = (DW'(cfg.grid_width) < DW'(MAX_WIDTH)) ? DW'(cfg.grid_width) : DW'(MAX_WIDTH);
	assign eff_h = (DW'(cfg.grid_height) < DW'(MAX_HEIGHT)) ?
		DW'(cfg.grid_height) : DW'(MAX_HEIGHT);
	assign tiny      = (eff_w < DW'(3)) || (eff_h < DW'(3));
	assign out_rng   = (DW'(req.cell_x) >= eff_w) || (DW'(req.cell_y) >= eff_h);
	assign y_last    = DW'(y_q) == (eff_h - DW'(2));
	assign col_last  = DW'(x_q) == (eff_w - DW'(2));
	assign pass_last = 4'(pass_q + 4'd1) == cfg.pass_count;

	// A column never written reads as all walls
	assign rd_col = rd_vld_q ? mem_rdata : '1;

	// Cell write: modify one bit of the fetched column
	assign cy = YW'(req_q.cell_y);
	always_comb begin
		cell_col     = rd_col;
		cell_col[cy] = req_q.wall_in;
	end

	// Count walls in the 3x3 window and apply the rule
	assign ym = YW'(y_q - YW'(1));
	assign yp = YW'(y_q + YW'(1));
	always_comb begin
		cnt = 4'(prev_q[ym]) + 4'(prev_q[y_q]) + 4'(prev_q[yp])
			+ 4'(cur_q[ym]) + 4'(cur_q[y_q]) + 4'(cur_q[yp])
			+ 4'(next_q[ym]) + 4'(next_q[y_q]) + 4'(next_q[yp]);
		cell_wall = (cnt >= cfg.crowd_limit) || ($signed({1'b0, cnt}) <= cfg.sparse_limit);
	end

	// Load the output register once it is free or being drained
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp_ready);

	// Memory requests per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = x_q;
		mem_wdata = cur_q;
		mem_re    = 1'b0;
		mem_raddr = XW'(req.cell_x);
		case (state_q)
			ST_IDLE: begin
				mem_re = req_valid && !out_rng &&
					((req.func == FUNC_WRITE) || (req.func == FUNC_READ));
			end
			ST_CELL_DATA: begin
				mem_we    = req_q.func == FUNC_WRITE;
				mem_waddr = XW'(req_q.cell_x);
				mem_wdata = cell_col;
			end
			ST_LOAD0: begin
				mem_re    = 1'b1;
				mem_raddr = XW'(0);
			end
			ST_LOAD1: begin
				mem_re    = 1'b1;
				mem_raddr = XW'(1);
			end
			ST_LOAD2: begin
				mem_re    = 1'b1;
				mem_raddr = XW'(2);
			end
			ST_COL: begin
				mem_we    = 1'b1;
				mem_re    = !col_last;
				mem_raddr = XW'(x_q + XW'(2));
			end
			default: ;
		endcase
	end

	// Sequencer, column valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			pass_q      <= '0;
			col_vld_q   <= '0;
			rd_vld_q    <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				col_vld_q[mem_waddr] <= 1'b1;
			end
			if (mem_re) begin
				rd_vld_q <= col_vld_q[mem_raddr];
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req.func)
							FUNC_WRITE, FUNC_READ: begin
								state_q <= out_rng ? ST_RESULT : ST_CELL_DATA;
							end
							FUNC_RUN: begin
								pass_q  <= '0;
								state_q <= (tiny || (cfg.pass_count == 4'd0)) ?
									ST_RESULT : ST_LOAD0;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_CELL_DATA: state_q <= ST_RESULT;
				ST_LOAD0:     state_q <= ST_LOAD1;
				ST_LOAD1:     state_q <= ST_LOAD2;
				ST_LOAD2:     state_q <= ST_LOAD3;
				ST_LOAD3: begin
					x_q     <= XW'(1);
					y_q     <= YW'(1);
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					if (y_last) begin
						state_q <= ST_COL;
					end else begin
						y_q <= YW'(y_q + YW'(1));
					end
				end
				ST_COL: begin
					if (!col_last) begin
						x_q     <= XW'(x_q + XW'(1));
						state_q <= ST_FILL;
					end else if (pass_last) begin
						state_q <= ST_RESULT;
					end else begin
						pass_q  <= 4'(pass_q + 4'd1);
						state_q <= ST_LOAD0;
					end
				end
				ST_FILL: begin
					y_q     <= YW'(1);
					state_q <= ST_CELL;
				end
				ST_RESULT: begin
					if (rsp_load) begin
						rsp_q.wall_out <= res_wall_q;
						rsp_q.status   <= res_status_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Column window registers and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q        <= req;
					res_wall_q   <= 1'b0;
					res_status_q <= out_rng &&
						((req.func == FUNC_WRITE) || (req.func == FUNC_READ));
				end
			end
			ST_CELL_DATA: begin
				res_wall_q <= (req_q.func == FUNC_READ) ? rd_col[cy] : 1'b0;
			end
			ST_LOAD1: prev_q <= rd_col;
			ST_LOAD2: cur_q  <= rd_col;
			ST_LOAD3: next_q <= rd_col;
			ST_CELL:  cur_q[y_q] <= cell_wall;
			ST_COL: begin
				if (!col_last) begin
					prev_q <= cur_q;
					cur_q  <= next_q;
				end
			end
			ST_FILL:  next_q <= rd_col;
			default: ;
		endcase
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/grid_cellular_automaton_smoother_unit.sv
// Cell write or read: the column is fetched, then modified or sampled; out-of-range or no-op
// items go straight to the result. Smoothing run: P passes on a W x H grid, one interior cell
// per cycle within a column, set by the single column memory port and the in-place chain.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset is asynchronous, active low: registers return to defaults and every column reads
// as all walls until first written.
module grid_cellular_automaton_smoother_unit import gcas_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	localparam int XW = $clog2(MAX_WIDTH);

	cfg_t                  cfg;
	logic                  mem_we, mem_re;
	logic [XW-1:0]         mem_waddr, mem_raddr;
	logic [MAX_HEIGHT-1:0] mem_wdata, mem_rdata;

	gcas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gcas_engine #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Grid store: one entry per column, one bit per row
	gcas_ram #(
		.WIDTH (MAX_HEIGHT),
		.DEPTH (MAX_WIDTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### bench/tb_grid_cellular_automaton_smoother_unit.sv
`timescale 1ns / 1ps

module tb_grid_cellular_automaton_smoother_unit;
	import gcas_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int STUCK_LIMIT = 250000;
	localparam int BACKLOG_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 60;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;

	// Predictor state: the cave grid and the register copy
	bit   wall_map [0:MAX_W*MAX_H-1];
	cfg_t cave_cfg;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	rsp_t want;
	bit   req_took = 1'b0;
	int   idle_pct = 36;
	int   mismatches = 0;
	int   stuck_cycles = 0;
	bit   start_backlog = 1'b0;
	bit   backlog_done = 1'b0;
	int   backlog_left = 0;

	grid_cellular_automaton_smoother_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [6:0] d, input int lim);
		return (int'(d) < lim) ? int'(d) : lim;
	endfunction

	// In-place smoothing passes over the interior cells, x outer, y inner
	function automatic void smooth_cave();
		int ew, eh, lo, hi, cnt;
		ew = eff_dim(cave_cfg.grid_width, MAX_W);
		eh = eff_dim(cave_cfg.grid_height, MAX_H);
		lo = int'($signed(cave_cfg.sparse_limit));
		hi = int'(cave_cfg.crowd_limit);
		if (ew < 3 || eh < 3)
			return;
		for (int p = 0; p < int'(cave_cfg.pass_count); p++)
			for (int x = 1; x < ew - 1; x++)
				for (int y = 1; y < eh - 1; y++) begin
					cnt = 0;
					for (int dx = -1; dx <= 1; dx++)
						for (int dy = -1; dy <= 1; dy++)
							cnt += wall_map[(y + dy) * MAX_W + x + dx];
					wall_map[y * MAX_W + x] = (cnt >= hi || cnt <= lo);
				end
	endfunction

	// Apply one item to the grid copy and return the result it should give
	function automatic rsp_t predict_cave(input req_t it);
		rsp_t r;
		int ew, eh, idx;
		r = '0;
		ew = eff_dim(cave_cfg.grid_width, MAX_W);
		eh = eff_dim(cave_cfg.grid_height, MAX_H);
		idx = int'(it.cell_y) * MAX_W + int'(it.cell_x);
		case (it.func)
			FUNC_WRITE, FUNC_READ: begin
				if (int'(it.cell_x) >= ew || int'(it.cell_y) >= eh)
					r.status = 1'b1;
				else if (it.func == FUNC_WRITE)
					wall_map[idx] = it.wall_in;
				else
					r.wall_out = wall_map[idx];
			end
			FUNC_RUN: smooth_cave();
			default: ;
		endcase
		return r;
	endfunction

	function automatic req_t cave_req(input logic [1:0] f, input int x, input int y,
			input logic wv);
		req_t it;
		it.func = f;
		it.cell_x = x[5:0];
		it.cell_y = y[5:0];
		it.wall_in = wv;
		return it;
	endfunction

	// Random item: mostly in-range writes and reads, some runs, some noise
	function automatic req_t cave_item();
		req_t it;
		int ew, eh, pick;
		ew = eff_dim(cave_cfg.grid_width, MAX_W);
		eh = eff_dim(cave_cfg.grid_height, MAX_H);
		it = cave_req(FUNC_RUN, $urandom_range(63), $urandom_range(63),
			1'($urandom_range(1)));
		pick = $urandom_range(99);
		if (pick >= 10 && pick < 14)
			it.func = FUNC_NONE;
		else if (pick >= 14) begin
			it.func = (pick < 55) ? FUNC_WRITE : FUNC_READ;
			if (pick % 10 != 0 && ew > 0 && eh > 0) begin
				it.cell_x = 6'($urandom_range(ew - 1));
				it.cell_y = 6'($urandom_range(eh - 1));
			end
		end
		return it;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_cave(input int w, input int h, input int passes, input int hi,
			input int lo);
		write_reg(REG_GRID_WIDTH, {25'd0, w[6:0]});
		write_reg(REG_GRID_HEIGHT, {25'd0, h[6:0]});
		write_reg(REG_PASS_COUNT, {28'd0, passes[3:0]});
		write_reg(REG_CROWD_LIMIT, {28'd0, hi[3:0]});
		write_reg(REG_SPARSE_LIMIT, {27'd0, lo[4:0]});
		cave_cfg.grid_width = w[6:0];
		cave_cfg.grid_height = h[6:0];
		cave_cfg.pass_count = passes[3:0];
		cave_cfg.crowd_limit = hi[3:0];
		cave_cfg.sparse_limit = lo[4:0];
	endtask

	// Hold until every item is sent and every result is back
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Sender: present the next item once the current one is taken
	always @(negedge clk) begin
		if (!req_valid || req_took) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (start_backlog && !backlog_done) begin
			backlog_left = BACKLOG_CYCLES;
			backlog_done = 1'b1;
		end
		if (backlog_left > 0) begin
			backlog_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Check results against the oldest expectation, then predict accepted items
	always @(posedge clk) begin
		req_took = req_valid && req_ready;
		if (arst_n) begin
			stuck_cycles++;
			if (rsp_valid && rsp_ready) begin
				stuck_cycles = 0;
				if (expected_rsps.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %b", rsp));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.wall_out !== want.wall_out)
						flag_mismatch($sformatf("wall_out %b, expected %b",
							rsp.wall_out, want.wall_out));
					if (rsp.status !== want.status)
						flag_mismatch($sformatf("status %b, expected %b",
							rsp.status, want.status));
				end
			end
			if (req_took) begin
				stuck_cycles = 0;
				expected_rsps.push_back(predict_cave(req));
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[grid_cellular_automaton_smoother_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int w, h, hi, lo, passes, shape;
		foreach (wall_map[i])
			wall_map[i] = 1'b1;
		cave_cfg.grid_width = GRID_DIM_RESET;
		cave_cfg.grid_height = GRID_DIM_RESET;
		cave_cfg.pass_count = PASS_COUNT_RESET;
		cave_cfg.crowd_limit = CROWD_LIMIT_RESET;
		cave_cfg.sparse_limit = SPARSE_LIMIT_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset grid: corners, unused code, one full-size pass
		pending_reqs.push_back(cave_req(FUNC_READ, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 0, 0, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 63, 63, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 63, 63, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_NONE, 63, 63, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 31, 32, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 32, 31, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_RUN, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 31, 31, 1'b0));
		wait_idle();

		// Small grid, low limit disabled: edges of the grid and just past them
		program_cave(10, 8, 2, 5, -1);
		pending_reqs.push_back(cave_req(FUNC_WRITE, 9, 7, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 10, 0, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_READ, 0, 8, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 63, 63, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 4, 4, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_RUN, 63, 63, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_READ, 4, 4, 1'b0));
		wait_idle();

		// Oversized grid, most passes, limits that never make a wall
		program_cave(127, 100, 15, 15, -16);
		pending_reqs.push_back(cave_req(FUNC_RUN, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 1, 1, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 0, 0, 1'b0));
		wait_idle();

		// Grid too narrow to have an interior, limits that always make a wall
		program_cave(2, 64, 3, 0, 15);
		pending_reqs.push_back(cave_req(FUNC_WRITE, 1, 5, 1'b1));
		pending_reqs.push_back(cave_req(FUNC_WRITE, 2, 5, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_RUN, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_READ, 1, 5, 1'b0));
		wait_idle();

		// Empty grid, zero passes, and a write to an unmapped register
		program_cave(0, 0, 0, 10, 9);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		pending_reqs.push_back(cave_req(FUNC_READ, 0, 0, 1'b0));
		pending_reqs.push_back(cave_req(FUNC_RUN, 0, 0, 1'b0));
		wait_idle();

		// Random phases, each with a fresh geometry and rule
		for (int phase = 0; phase < 9; phase++) begin
			shape = $urandom_range(9);
			if (shape == 7) begin
				w = $urandom_range(65, 127);
				h = $urandom_range(3, 5);
			end else if (shape == 8) begin
				w = $urandom_range(3, 5);
				h = $urandom_range(65, 127);
			end else if (shape == 9) begin
				w = $urandom_range(2);
				h = $urandom_range(20);
				if ($urandom_range(1))
					{w, h} = {h, w};
			end else begin
				w = $urandom_range(3, 14);
				h = $urandom_range(3, 14);
			end
			passes = $urandom_range(15);
			hi = ($urandom_range(9) == 0) ? $urandom_range(11, 15) : $urandom_range(10);
			lo = ($urandom_range(9) == 0) ? int'($urandom_range(31)) - 16
				: int'($urandom_range(10)) - 1;
			program_cave(w, h, passes, hi, lo);

			// One phase runs flat out and backs the block up
			idle_pct = (phase == 4) ? 0 : 36;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_reqs.push_back(cave_item());
			if (phase == 4)
				start_backlog = 1'b1;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[grid_cellular_automaton_smoother_unit] OK");
		else
			$display("[grid_cellular_automaton_smoother_unit] ERROR");
		$finish;
	end

endmodule
